>>> rtl/core/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and constants for the sorted score table.
// ----------------------------------------------------------------------------
package sst_pkg;

	localparam int TableDepthDefault = 128;
	localparam logic [7:0] TopLimitReset = 8'd30;

	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_DELTA = 3'd1,
		OP_SET   = 3'd2,
		OP_FIND  = 3'd3,
		OP_READ  = 3'd4,
		OP_SORT  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2,
		ST_RANGE    = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]         operation;
		logic [15:0]        player_id;
		logic signed [31:0] value;
		logic [6:0]         position;
	} in_word_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [15:0]        found_id;
		logic signed [31:0] found_score;
		logic [7:0]         rank;
		logic               in_top;
		logic [7:0]         entry_count;
	} out_word_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIND,     // search for the first matching identifier
		S_SHIFT_L,  // close a slot by moving entries toward the head
		S_PLACE,    // locate insertion point
		S_SHIFT_R,  // move entries toward the tail to open a slot
		S_WRITE,
		S_RD_ISSUE,
		S_RD_TAKE,
		S_SORT_RD,
		S_SORT_CMP,
		S_SORT_END,
		S_DONE
	} fsm_t;

	typedef struct packed {
		logic [47:0] rd_data;
	} mem_rsp_t;

endpackage

>>> rtl/core/sst_mem.sv
// ----------------------------------------------------------------------------
// sst_mem
// Entry store: identifier and score per row, one write and one read port,
// registered read data.
// ----------------------------------------------------------------------------
module sst_mem import sst_pkg::*; #(
	parameter int TABLE_DEPTH = TableDepthDefault,
	localparam int AW = $clog2(TABLE_DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [47:0]   wdata,
	input  logic [AW-1:0] raddr,
	output mem_rsp_t      rsp
);

	logic [47:0] mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rsp.rd_data <= mem[raddr];
	end

endmodule

>>> rtl/core/sst_ctrl.sv
// ----------------------------------------------------------------------------
// sst_ctrl
// Sequencer: walks the entry store for search, shift, insert and sort.
// ----------------------------------------------------------------------------
module sst_ctrl import sst_pkg::*; #(
	parameter int TABLE_DEPTH = TableDepthDefault,
	localparam int AW = $clog2(TABLE_DEPTH),
	localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    top_limit,
	input  logic          in_valid,
	output logic          in_ready,
	input  in_word_t      in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output out_word_t     out_data,
	output logic          we,
	output logic [AW-1:0] waddr,
	output logic [47:0]   wdata,
	output logic [AW-1:0] raddr,
	input  mem_rsp_t      rsp
);

	fsm_t state_q, state_d;
	in_word_t req_q;
	logic [CW-1:0] cnt_q, idx_q;          // entry count, next read address
	logic pend_q;                         // read issued last cycle
	logic [CW-1:0] hole_q;                // slot to fill
	logic signed [31:0] key_q;            // score being placed
	logic [15:0] kid_q;
	logic [47:0] carry_q;                 // sort: element moving down the pass
	logic swapped_q, first_q;
	status_t st_q;
	logic [CW-1:0] rpos_q;                // result position
	logic [15:0] res_id_q;
	logic signed [31:0] res_sc_q;
	out_word_t res_q;
	logic res_v_q;

	logic [15:0] rd_id;
	logic signed [31:0] rd_sc;
	logic signed [32:0] sum;
	logic signed [31:0] sat;
	logic [7:0] rank_w;
	logic at_end, find_hit, place_hit, sort_swap, in_full, in_range, done_go, has_entry;

	assign rd_id = rsp.rd_data[47:32];
	assign rd_sc = rsp.rd_data[31:0];
	assign sum = 33'(rd_sc) + 33'(req_q.value);
	always_comb begin
		if (sum > 33'sd2147483647) begin
			sat = 32'sh7FFFFFFF;
		end else if (sum < -33'sd2147483648) begin
			sat = 32'sh80000000;
		end else begin
			sat = sum[31:0];
		end
	end
	assign rank_w = 8'(rpos_q) + 8'd1;

	assign at_end = idx_q >= cnt_q;
	assign find_hit = pend_q && (rd_id == req_q.player_id);
	assign place_hit = pend_q && !(rd_sc > key_q);
	assign sort_swap = $signed(carry_q[31:0]) < rd_sc;
	assign in_full = cnt_q >= CW'(TABLE_DEPTH);
	assign in_range = 32'(in_data.position) >= 32'(cnt_q);
	assign done_go = !res_v_q || out_ready;
	assign has_entry = (st_q == ST_OK) && (req_q.operation <= OP_READ);

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = res_v_q;
	assign out_data = res_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (in_data.operation)
						OP_ADD: state_d = in_full ? S_DONE : S_PLACE;
						OP_DELTA, OP_SET, OP_FIND: state_d = S_FIND;
						OP_READ: state_d = in_range ? S_DONE : S_RD_ISSUE;
						OP_SORT: state_d = (cnt_q < CW'(2)) ? S_DONE : S_SORT_RD;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_FIND: begin
				if (find_hit) begin
					unique case (req_q.operation)
						OP_FIND: state_d = S_DONE;
						OP_SET: state_d = S_WRITE;
						default: state_d = S_SHIFT_L;
					endcase
				end else if (at_end) begin
					state_d = S_DONE;
				end
			end
			S_SHIFT_L: if (at_end) state_d = S_PLACE;
			S_PLACE: if (place_hit || at_end) state_d = S_SHIFT_R;
			S_SHIFT_R: if (idx_q <= hole_q) state_d = S_WRITE;
			S_WRITE: state_d = S_DONE;
			S_RD_ISSUE: state_d = S_RD_TAKE;
			S_RD_TAKE: state_d = S_DONE;
			S_SORT_RD: state_d = S_SORT_CMP;
			S_SORT_CMP: if (!first_q && idx_q == cnt_q) state_d = S_SORT_END;
			S_SORT_END: state_d = swapped_q ? S_SORT_RD : S_DONE;
			S_DONE: if (done_go) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs: memory port
	always_comb begin
		we = 1'b0;
		waddr = AW'(idx_q);
		wdata = rsp.rd_data;
		raddr = AW'(idx_q);
		unique case (state_q)
			S_SHIFT_L: begin
				we = pend_q;
				waddr = AW'(idx_q - CW'(2));
			end
			S_SHIFT_R: begin
				raddr = AW'(idx_q - CW'(1));
				we = pend_q;
				waddr = AW'(idx_q + CW'(1));
			end
			S_WRITE: begin
				we = 1'b1;
				waddr = AW'(hole_q);
				wdata = {kid_q, key_q};
			end
			S_SORT_RD: raddr = '0;
			S_SORT_CMP: begin
				we = !first_q;
				waddr = AW'(idx_q - CW'(2));
				wdata = sort_swap ? rsp.rd_data : carry_q;
			end
			S_SORT_END: begin
				we = 1'b1;
				waddr = AW'(cnt_q - CW'(1));
				wdata = carry_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
			pend_q <= 1'b0;
			hole_q <= '0;
			key_q <= '0;
			kid_q <= '0;
			carry_q <= '0;
			swapped_q <= 1'b0;
			first_q <= 1'b0;
			st_q <= ST_OK;
			rpos_q <= '0;
			res_id_q <= '0;
			res_sc_q <= '0;
			res_q <= '0;
			res_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && done_go) begin
				res_v_q <= 1'b1;
				res_q.status <= st_q;
				res_q.entry_count <= 8'(cnt_q);
				if (has_entry) begin
					res_q.found_id <= res_id_q;
					res_q.found_score <= res_sc_q;
					res_q.rank <= rank_w;
					res_q.in_top <= (rank_w != 8'd0) && (rank_w <= top_limit);
				end else begin
					res_q.found_id <= '0;
					res_q.found_score <= '0;
					res_q.rank <= '0;
					res_q.in_top <= 1'b0;
				end
			end else if (out_ready) begin
				res_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q <= in_data;
						pend_q <= 1'b0;
						key_q <= in_data.value;
						kid_q <= in_data.player_id;
						swapped_q <= 1'b0;
						first_q <= 1'b1;
						rpos_q <= CW'(in_data.position);
						idx_q <= (in_data.operation == OP_READ) ? CW'(in_data.position) : '0;
						if (in_data.operation == OP_ADD && in_full) begin
							st_q <= ST_FULL;
						end else if (in_data.operation == OP_READ && in_range) begin
							st_q <= ST_RANGE;
						end else begin
							st_q <= ST_OK;
						end
					end
				end
				// read issued at idx_q, data of idx_q-1 compared when pend_q
				S_FIND: begin
					if (find_hit) begin
						rpos_q <= idx_q - CW'(1);
						hole_q <= idx_q - CW'(1);
						res_id_q <= rd_id;
						res_sc_q <= rd_sc;
						kid_q <= rd_id;
						if (req_q.operation == OP_DELTA) begin
							key_q <= sat;
						end
						pend_q <= 1'b0;
					end else if (at_end) begin
						st_q <= ST_NOTFOUND;
						pend_q <= 1'b0;
					end else begin
						idx_q <= idx_q + CW'(1);
						pend_q <= 1'b1;
					end
				end
				// write [i-1] <= [i]
				S_SHIFT_L: begin
					if (at_end) begin
						cnt_q <= cnt_q - CW'(1);
						idx_q <= '0;
						pend_q <= 1'b0;
					end else begin
						idx_q <= idx_q + CW'(1);
						pend_q <= 1'b1;
					end
				end
				// first position with score <= key
				S_PLACE: begin
					if (place_hit) begin
						hole_q <= idx_q - CW'(1);
						idx_q <= cnt_q;
						pend_q <= 1'b0;
					end else if (at_end) begin
						hole_q <= cnt_q;
						idx_q <= cnt_q;
						pend_q <= 1'b0;
					end else begin
						idx_q <= idx_q + CW'(1);
						pend_q <= 1'b1;
					end
				end
				// walk down from the tail: write [i+1] <= [i]
				S_SHIFT_R: begin
					if (idx_q > hole_q) begin
						idx_q <= idx_q - CW'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
				end
				S_WRITE: begin
					if (req_q.operation != OP_SET) begin
						cnt_q <= cnt_q + CW'(1);
					end
					rpos_q <= hole_q;
					res_id_q <= kid_q;
					res_sc_q <= key_q;
				end
				S_RD_TAKE: begin
					res_id_q <= rd_id;
					res_sc_q <= rd_sc;
				end
				S_SORT_RD: begin
					idx_q <= CW'(1);
					first_q <= 1'b1;
				end
				// carry_q is the element now at idx_q-2
				S_SORT_CMP: begin
					if (first_q) begin
						first_q <= 1'b0;
						carry_q <= rsp.rd_data;
					end else if (sort_swap) begin
						swapped_q <= 1'b1;
					end else begin
						carry_q <= rsp.rd_data;
					end
					idx_q <= idx_q + CW'(1);
				end
				S_SORT_END: swapped_q <= 1'b0;
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/core/sorted_score_table_core.sv
// ----------------------------------------------------------------------------
// sorted_score_table_core
// Score table kept in descending order in one entry memory.
// ----------------------------------------------------------------------------
// One word at a time. A finished result waits in the output register; the
// next word is still taken, but its result waits until the register is free.
// Walks go one entry per cycle through the single read port, whose read data
// is registered. Find and set search for the identifier; add searches for the
// slot, then shifts the tail; add-to-score searches, closes the gap, then does
// the add walk. Sort runs bubble passes until a pass makes no swap, up to
// count passes. The sequencer returns to idle after each word.
module sorted_score_table_core import sst_pkg::*; #(
	parameter int TABLE_DEPTH = TableDepthDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic [7:0] top_limit_q;
	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [47:0] wdata;
	mem_rsp_t rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_limit_q <= TopLimitReset;
		end else if (cfg_we) begin
			top_limit_q <= cfg_wdata;
		end
	end

	sst_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rsp(rsp)
	);

	sst_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .top_limit(top_limit_q),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rsp(rsp)
	);

endmodule

>>> tb/tb_sorted_score_table_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_score_table_core
// Regression for the sorted score table core. A directed opening covers the
// empty table, duplicates, saturation, every operation and unused codes;
// random phases under several top limits and a full table follow. A scoreboard
// tracks the table contents and checks every result word field by field.
// ----------------------------------------------------------------------------
module tb_sorted_score_table_core;
	import sst_pkg::*;

	localparam int Depth = 128;

	class score_table_board;
		logic [15:0]        ids[Depth];
		logic signed [31:0] scores[Depth];
		int                 n;
		logic [7:0]         top_limit;
		out_word_t          expected_q[$];
		int                 errors;

		function new();
			n = 0;
			top_limit = TopLimitReset;
			errors = 0;
		endfunction

		function int place(logic [15:0] id, logic signed [31:0] score);
			int p;
			p = 0;
			while (p < n && scores[p] > score) p++;
			for (int i = n; i > p; i--) begin
				ids[i] = ids[i-1];
				scores[i] = scores[i-1];
			end
			ids[p] = id;
			scores[p] = score;
			n++;
			return p;
		endfunction

		function void unplace(int p);
			for (int i = p; i + 1 < n; i++) begin
				ids[i] = ids[i+1];
				scores[i] = scores[i+1];
			end
			n--;
		endfunction

		function int lookup(logic [15:0] id);
			for (int i = 0; i < n; i++)
				if (ids[i] == id) return i;
			return -1;
		endfunction

		function void resort();
			bit swapped;
			logic [15:0] ti;
			logic signed [31:0] ts;
			if (n < 2) return;
			do begin
				swapped = 0;
				for (int i = 0; i + 1 < n; i++) begin
					if (scores[i] < scores[i+1]) begin
						ti = ids[i]; ts = scores[i];
						ids[i] = ids[i+1]; scores[i] = scores[i+1];
						ids[i+1] = ti; scores[i+1] = ts;
						swapped = 1;
					end
				end
			end while (swapped);
		endfunction

		function void report_entry(ref out_word_t r, input int p);
			r.found_id = ids[p];
			r.found_score = scores[p];
			r.rank = 8'(p + 1);
			r.in_top = (p + 1) <= top_limit;
		endfunction

		function void note_input(in_word_t w);
			out_word_t r;
			int p;
			logic signed [32:0] sum;
			r = '0;
			r.status = ST_OK;
			case (w.operation)
				OP_ADD: begin
					if (n >= Depth) r.status = ST_FULL;
					else report_entry(r, place(w.player_id, w.value));
				end
				OP_DELTA: begin
					p = lookup(w.player_id);
					if (p < 0) r.status = ST_NOTFOUND;
					else begin
						sum = 33'(scores[p]) + 33'(w.value);
						unplace(p);
						if (sum > 33'sd2147483647) sum = 33'sd2147483647;
						else if (sum < -33'sd2147483648) sum = -33'sd2147483648;
						report_entry(r, place(w.player_id, sum[31:0]));
					end
				end
				OP_SET: begin
					p = lookup(w.player_id);
					if (p < 0) r.status = ST_NOTFOUND;
					else begin
						scores[p] = w.value;
						report_entry(r, p);
					end
				end
				OP_FIND: begin
					p = lookup(w.player_id);
					if (p < 0) r.status = ST_NOTFOUND;
					else report_entry(r, p);
				end
				OP_READ: begin
					if (w.position >= n) r.status = ST_RANGE;
					else report_entry(r, w.position);
				end
				OP_SORT: resort();
				default: ;
			endcase
			r.entry_count = 8'(n);
			expected_q.push_back(r);
		endfunction

		function void check_result(out_word_t got);
			out_word_t e;
			if (expected_q.size() == 0) begin
				$error("result word with nothing expected: %h", got);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.status !== e.status) begin
				$error("status exp %0d got %0d", e.status, got.status); errors++;
			end
			if (got.found_id !== e.found_id) begin
				$error("found_id exp %h got %h", e.found_id, got.found_id); errors++;
			end
			if (got.found_score !== e.found_score) begin
				$error("found_score exp %0d got %0d", e.found_score, got.found_score);
				errors++;
			end
			if (got.rank !== e.rank) begin
				$error("rank exp %0d got %0d", e.rank, got.rank); errors++;
			end
			if (got.in_top !== e.in_top) begin
				$error("in_top exp %0d got %0d", e.in_top, got.in_top); errors++;
			end
			if (got.entry_count !== e.entry_count) begin
				$error("entry_count exp %0d got %0d", e.entry_count, got.entry_count);
				errors++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	logic [7:0] cfg_wdata;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_data;

	score_table_board board;
	bit idle_on;
	int stall_left;

	sorted_score_table_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#200000000;
		$display("sorted_score_table_core regression: fail");
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready = 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 13) - 1;
				out_ready = 1'b0;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready) board.check_result(out_data);

	function automatic in_word_t make_word(logic [2:0] op, logic [15:0] id,
			logic signed [31:0] val, logic [6:0] pos);
		in_word_t w;
		w.operation = op;
		w.player_id = id;
		w.value = val;
		w.position = pos;
		return w;
	endfunction

	function automatic logic [15:0] pick_id();
		logic [15:0] pool[12] = '{16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'h0004,
			16'h0005, 16'h0006, 16'h0007, 16'h0008, 16'h0009, 16'hFFFF, 16'h8000};
		if ($urandom_range(0, 9) < 8) return pool[$urandom_range(0, 11)];
		return 16'($urandom);
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 3))
			0: case ($urandom_range(0, 3))
				0: return 32'sh7FFFFFFF;
				1: return 32'sh80000000;
				2: return 32'sd0;
				default: return -32'sd1;
			endcase
			1: return $signed($urandom_range(0, 40)) - 20;
			2: return $signed($urandom_range(0, 2000)) - 1000;
			default: return $signed($urandom);
		endcase
	endfunction

	function automatic in_word_t random_word(int cnt);
		int r;
		logic [2:0] op;
		logic [6:0] pos;
		r = $urandom_range(0, 99);
		if (r < 25) op = OP_ADD;
		else if (r < 45) op = OP_DELTA;
		else if (r < 55) op = OP_SET;
		else if (r < 75) op = OP_FIND;
		else if (r < 95) op = OP_READ;
		else if (r < 97) op = OP_SORT;
		else op = 3'($urandom_range(6, 7));
		if ($urandom_range(0, 1) && cnt > 0) pos = 7'($urandom_range(0, cnt));
		else pos = 7'($urandom);
		return make_word(op, pick_id(), pick_value(), pos);
	endfunction

	task automatic send_word(in_word_t w);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 13);
			@(negedge clk) in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		in_data = w;
		do @(posedge clk); while (!in_ready);
		board.note_input(w);
	endtask

	task automatic drain();
		@(negedge clk) in_valid = 1'b0;
		while (board.expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_top_limit(logic [7:0] v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk) cfg_we = 1'b0;
		board.top_limit = v;
	endtask

	initial begin
		logic [7:0] limits[4] = '{8'd0, 8'd128, 8'd1, 8'd30};
		board = new();
		idle_on = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// empty table corners
		send_word(make_word(OP_READ, 16'h0000, 32'sd0, 7'd0));
		send_word(make_word(OP_FIND, 16'hFFFF, 32'sd0, 7'd127));
		send_word(make_word(OP_DELTA, 16'h0001, 32'sd5, 7'd0));
		send_word(make_word(OP_SET, 16'h0001, 32'sd5, 7'd0));
		send_word(make_word(OP_SORT, 16'h0000, 32'sd0, 7'd0));
		// extremes, equal scores, duplicates
		send_word(make_word(OP_ADD, 16'h0000, 32'sh7FFFFFFF, 7'd0));
		send_word(make_word(OP_ADD, 16'hFFFF, 32'sh80000000, 7'd0));
		send_word(make_word(OP_ADD, 16'h0005, 32'sd0, 7'd0));
		send_word(make_word(OP_ADD, 16'h0005, 32'sd0, 7'd0));
		send_word(make_word(OP_ADD, 16'h0007, 32'sd0, 7'd0));
		// saturation both ways
		send_word(make_word(OP_DELTA, 16'h0000, 32'sd100, 7'd0));
		send_word(make_word(OP_DELTA, 16'hFFFF, -32'sd100, 7'd0));
		send_word(make_word(OP_DELTA, 16'h0007, 32'sh7FFFFFFF, 7'd0));
		send_word(make_word(OP_SET, 16'h0005, -32'sd1, 7'd0));
		send_word(make_word(OP_SET, 16'hFFFF, 32'sd1000, 7'd0));
		send_word(make_word(OP_FIND, 16'h0005, 32'sd0, 7'd0));
		send_word(make_word(OP_READ, 16'h0000, 32'sd0, 7'd4));
		send_word(make_word(OP_READ, 16'h0000, 32'sd0, 7'd5));
		send_word(make_word(OP_READ, 16'h0000, 32'sd0, 7'd127));
		send_word(make_word(OP_SORT, 16'h0000, 32'sd0, 7'd0));
		send_word(make_word(OP_READ, 16'h0000, 32'sd0, 7'd1));
		send_word(make_word(3'd6, 16'h1234, 32'sd7, 7'd3));
		send_word(make_word(3'd7, 16'h4321, 32'sd7, 7'd3));
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			write_top_limit(limits[ph]);
			idle_on = (ph != 3);
			for (int k = 0; k < 440; k++) send_word(random_word(board.n));
			drain();
		end

		// full table: top it up, then a refused add
		write_top_limit(8'($urandom_range(2, 127)));
		while (board.n < Depth)
			send_word(make_word(OP_ADD, pick_id(), pick_value(), 7'd0));
		send_word(make_word(OP_ADD, 16'hFFFF, 32'sd0, 7'd0));
		send_word(make_word(OP_READ, 16'h0000, 32'sd0, 7'd127));
		send_word(make_word(OP_SORT, 16'h0000, 32'sd0, 7'd0));
		drain();
		repeat (20) @(posedge clk);

		if (board.errors == 0 && board.expected_q.size() == 0)
			$display("sorted_score_table_core regression: pass");
		else
			$display("sorted_score_table_core regression: fail");
		$finish;
	end

endmodule
